// File: rtl/core/spq_pkg.sv
// Shared types, codes and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // fixed field widths
    localparam int VALUE_W          = 32;
    localparam int OCC_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // operation codes carried on the input word
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } spq_op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } spq_status_t;

    // controller states
    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_EXEC = 2'd1,
        CTL_RESP = 2'd2
    } spq_state_t;

    // controller to datapath
    typedef struct packed {
        logic        load;     // capture the input word
        logic        insert;   // place the held value in order
        logic        remove;   // pop the head and close the gap
        logic        store;    // latch the result word
        spq_status_t code;     // status code to latch
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        spq_op_t op;
        logic    full;
        logic    empty;
    } spq_stat_t;

endpackage

// File: rtl/core/spq_datapath.sv
// Datapath: sorted register row with per-slot compare-and-shift, count and result word.
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  spq_pkg::spq_cmd_t                  cmd,
    output spq_pkg::spq_stat_t                 stat,
    input  logic                               in_operation,
    input  logic signed [spq_pkg::VALUE_W-1:0] in_value,
    output logic        [1:0]                  res_status,
    output logic signed [spq_pkg::VALUE_W-1:0] res_removed_value,
    output logic        [spq_pkg::OCC_W-1:0]   res_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // held input word
    spq_op_t                    op_reg;
    logic signed [VALUE_W-1:0]  value_reg;

    // sorted row, ascending from slot 0
    logic signed [VALUE_W-1:0]  entry_reg  [CAPACITY];
    logic signed [VALUE_W-1:0]  entry_next [CAPACITY];
    logic [CAPACITY-1:0]        gt;

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;

    // result word
    spq_status_t                status_reg;
    logic signed [VALUE_W-1:0]  removed_reg;
    logic [CW+OCC_W-1:0]        count_ext;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= spq_op_t'(in_operation);
            value_reg <= in_value;
        end
    end

    // per-slot compare: occupied and strictly greater than the new value
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_slot
            assign gt[g] = (CW'(g) < count_reg) && (entry_reg[g] > value_reg);

            if (g == 0) begin : g_head
                always_comb begin
                    entry_next[g] = entry_reg[g];
                    if (cmd.insert) begin
                        if (gt[g] || (count_reg == CW'(g))) begin
                            entry_next[g] = value_reg;
                        end
                    end else if (cmd.remove) begin
                        if (CAPACITY > 1) begin
                            entry_next[g] = entry_reg[(g + 1) % CAPACITY];
                        end
                    end
                end
            end else begin : g_body
                always_comb begin
                    entry_next[g] = entry_reg[g];
                    if (cmd.insert) begin
                        if (gt[g-1]) begin
                            entry_next[g] = entry_reg[g-1];
                        end else if (gt[g] || (count_reg == CW'(g))) begin
                            entry_next[g] = value_reg;
                        end
                    end else if (cmd.remove) begin
                        if (g < CAPACITY - 1) begin
                            entry_next[g] = entry_reg[(g + 1) % CAPACITY];
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                entry_reg[g] <= entry_next[g];
            end
        end
    endgenerate

    // occupancy count
    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result word latch; removed value is zero unless the head left
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            status_reg  <= cmd.code;
            removed_reg <= cmd.remove ? entry_reg[0] : '0;
        end
    end

    assign stat.op    = op_reg;
    assign stat.full  = (count_reg == CW'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    assign count_ext         = {{OCC_W{1'b0}}, count_reg};
    assign res_status        = status_reg;
    assign res_removed_value = removed_reg;
    assign res_occupancy     = count_ext[OCC_W-1:0];

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("queue count above capacity");

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !stat.full)
        else $error("insert commanded on a full queue");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove |=> count_reg == $past(count_reg) - CW'(1))
        else $error("count did not drop after remove");

endmodule

// File: rtl/core/spq_controller.sv
// Controller: sequences capture, execute and result hand-off of one word.
`timescale 1ns / 1ps

module spq_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '{load: 1'b0, insert: 1'b0, remove: 1'b0, store: 1'b0,
                       code: ST_INSERTED};
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = CTL_EXEC;
                end
            end
            CTL_EXEC: begin
                cmd.store = 1'b1;
                if (stat.op == OP_INSERT) begin
                    if (stat.full) begin
                        cmd.code = ST_FULL;
                    end else begin
                        cmd.insert = 1'b1;
                        cmd.code   = ST_INSERTED;
                    end
                end else begin
                    if (stat.empty) begin
                        cmd.code = ST_EMPTY;
                    end else begin
                        cmd.remove = 1'b1;
                        cmd.code   = ST_REMOVED;
                    end
                end
                state_next = CTL_RESP;
            end
            CTL_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // checks
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output open together");

    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> m_valid)
        else $error("result not offered after execute");

    a_single_action: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.remove))
        else $error("insert and remove in one cycle");

endmodule

// File: rtl/core/sorted_priority_queue.sv
// Top level: sorted-row minimum priority queue, controller plus datapath.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  s_      | s_valid s_ready s_operation s_value          | in
//  m_      | m_valid m_ready m_status m_removed_value     | out
//          | m_occupancy                                  |
//
// One word at a time: capture, execute, offer result; the next word is taken
// only after the result word is taken, so m_ready held low stalls the queue.
// Insert and delete both finish in the execute state: every slot of the
// register row compares and shifts in parallel.
// aresetn is synchronous, active low; it empties the queue, row contents are
// not cleared. s_ready is low from capture until the result word is taken.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic signed [spq_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [1:0]                  m_status,
    output logic signed [spq_pkg::VALUE_W-1:0] m_removed_value,
    output logic        [spq_pkg::OCC_W-1:0]   m_occupancy
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_controller u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .in_operation      (s_operation),
        .in_value          (s_value),
        .res_status        (m_status),
        .res_removed_value (m_removed_value),
        .res_occupancy     (m_occupancy)
    );

endmodule
